// ----- sv/xfd_pkg.sv -----
// Shared constants for the XOR frame decoder.
package xfd_pkg;

  localparam int unsigned DEF_BUFFER_BYTES = 512;
  localparam int unsigned FRAME_OVERHEAD   = 8;

  localparam logic [8:0] MAX_PAYLOAD_RST = 9'd504;

  localparam logic [7:0] START_CH = 8'h40;
  localparam logic [7:0] TRAIL_CH = 8'h23;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_CHK  = 2'd1;
  localparam status_t ST_BAD_TRL  = 2'd2;
  localparam status_t ST_TOO_LONG = 2'd3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

endpackage

// ----- sv/xor_frame_decoder.sv -----
// Byte-serial decoder for length-prefixed frames with an XOR checksum.
// Each byte passes through the input register, and its result through the result register.
// Throughput: one byte per cycle while results drain; a stalled result holds
// the parser, and once the input register is full the input stalls too.
// Reset (rst_n, synchronous, active low) returns to the start-byte hunt and
// sets max_payload to 504.
module xor_frame_decoder
  import xfd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_max_payload,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_command,
  output status_t    out_status,
  output logic       out_last
);

  localparam logic [16:0] BUF_LIM = 17'(BUFFER_BYTES - FRAME_OVERHEAD);

  localparam logic [3:0] PH_HUNT1 = 4'd0;
  localparam logic [3:0] PH_HUNT2 = 4'd1;
  localparam logic [3:0] PH_LENHI = 4'd2;
  localparam logic [3:0] PH_LENLO = 4'd3;
  localparam logic [3:0] PH_CMD   = 4'd4;
  localparam logic [3:0] PH_PAY   = 4'd5;
  localparam logic [3:0] PH_CHK   = 4'd6;
  localparam logic [3:0] PH_TR1   = 4'd7;
  localparam logic [3:0] PH_TR2   = 4'd8;

  logic [8:0]  max_payload_r;
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        advance;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic        chk_bad_r, chk_bad_nxt;
  logic        trl_bad_r, trl_bad_nxt;

  logic        emit;
  logic        kind_nxt;
  logic [7:0]  data_nxt;
  logic [7:0]  ocmd_nxt;
  status_t     status_nxt;

  logic        out_vld_r;
  logic        kind_r;
  logic [7:0]  data_r;
  logic [7:0]  ocmd_r;
  status_t     status_r;

  logic [16:0] limit;
  logic [15:0] len_full;
  logic        trl_bad_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  // input stage
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // frame parser
  assign limit = ({8'd0, max_payload_r} < BUF_LIM) ? {8'd0, max_payload_r} : BUF_LIM;
  assign len_full    = {remaining_r[7:0], in_byte_r};
  assign trl_bad_end = trl_bad_r || (in_byte_r != TRAIL_CH);

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    xor_nxt       = xor_r;
    cmd_nxt       = cmd_r;
    chk_bad_nxt   = chk_bad_r;
    trl_bad_nxt   = trl_bad_r;
    emit          = 1'b0;
    kind_nxt      = KIND_DATA;
    data_nxt      = 8'd0;
    ocmd_nxt      = cmd_r;
    status_nxt    = ST_OK;
    unique case (phase_r)
      PH_HUNT2: begin
        phase_nxt = (in_byte_r == START_CH) ? PH_LENHI : PH_HUNT1;
      end
      PH_LENHI: begin
        remaining_nxt = {8'd0, in_byte_r};
        xor_nxt       = in_byte_r;
        phase_nxt     = PH_LENLO;
      end
      PH_LENLO: begin
        xor_nxt = xor_r ^ in_byte_r;
        if ({1'b0, len_full} > limit) begin
          phase_nxt     = PH_HUNT1;
          remaining_nxt = 16'd0;
          emit          = 1'b1;
          kind_nxt      = KIND_STATUS;
          ocmd_nxt      = 8'd0;
          status_nxt    = ST_TOO_LONG;
        end else begin
          remaining_nxt = len_full;
          phase_nxt     = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = in_byte_r;
        xor_nxt   = xor_r ^ in_byte_r;
        phase_nxt = (remaining_r == 16'd0) ? PH_CHK : PH_PAY;
      end
      PH_PAY: begin
        xor_nxt       = xor_r ^ in_byte_r;
        remaining_nxt = remaining_r - 16'd1;
        if (remaining_r == 16'd1) begin
          phase_nxt = PH_CHK;
        end
        emit     = 1'b1;
        kind_nxt = KIND_DATA;
        data_nxt = in_byte_r;
      end
      PH_CHK: begin
        chk_bad_nxt = (in_byte_r != xor_r);
        phase_nxt   = PH_TR1;
      end
      PH_TR1: begin
        trl_bad_nxt = (in_byte_r != TRAIL_CH);
        phase_nxt   = PH_TR2;
      end
      PH_TR2: begin
        trl_bad_nxt = trl_bad_end;
        phase_nxt   = PH_HUNT1;
        emit        = 1'b1;
        kind_nxt    = KIND_STATUS;
        status_nxt  = trl_bad_end ? ST_BAD_TRL : (chk_bad_r ? ST_BAD_CHK : ST_OK);
      end
      default: begin
        phase_nxt = (in_byte_r == START_CH) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT1;
      remaining_r <= 16'd0;
      xor_r       <= 8'd0;
      cmd_r       <= 8'd0;
      chk_bad_r   <= 1'b0;
      trl_bad_r   <= 1'b0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      xor_r       <= xor_nxt;
      cmd_r       <= cmd_nxt;
      chk_bad_r   <= chk_bad_nxt;
      trl_bad_r   <= trl_bad_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= emit;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      kind_r   <= kind_nxt;
      data_r   <= data_nxt;
      ocmd_r   <= ocmd_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_kind      = kind_r;
  assign out_data_byte = data_r;
  assign out_command   = ocmd_r;
  assign out_status    = status_r;
  assign out_last      = kind_r;

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_vld_r && !out_ready))
    else $error("input stalled without a held result");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && kind_r == KIND_DATA) |-> (status_r == ST_OK && data_r == data_r))
    else $error("payload result carries a status");

  a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && kind_r == KIND_STATUS) |-> (data_r == 8'd0))
    else $error("status result carries data");

  a_too_long_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r == ST_TOO_LONG) |-> (ocmd_r == 8'd0 && kind_r == KIND_STATUS))
    else $error("length-too-long status with command");

  a_hunt_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit && kind_nxt == KIND_STATUS) |=> (phase_r == PH_HUNT1))
    else $error("parser not hunting after end of frame");

endmodule
